// ----- design/quadtree_tile_allocator_unit_macros.svh -----
// Assertion macros used by the checker module of the tile allocator.
// Depends on nothing; included by bare file name.
`ifndef QUADTREE_TILE_ALLOCATOR_UNIT_MACROS_SVH
`define QUADTREE_TILE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define QTA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tile allocator assertion failed");

// Next-cycle implication, off while reset is asserted.
`define QTA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tile allocator assertion failed");

// Next-cycle implication that is also checked during reset.
`define QTA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tile allocator assertion failed");

`endif

// ----- design/qta_pkg.sv -----
// Constants, state type and helper functions of the quadtree tile allocator.
// Depends on nothing; used by the top level and its checker.
package qta_pkg;

    localparam int MAX_LEVELS = 5;
    localparam int NODE_COUNT = ((4 ** MAX_LEVELS) - 1) / 3;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int BLK_W      = $clog2(MAX_LEVELS + 1);

    localparam int LOG_W   = 4;
    localparam int LVL_W   = 3;
    localparam int SIZE_W  = 16;
    localparam int POS_W   = 5;
    localparam int LEVEL_W = 3;
    localparam int REQ_W   = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TILE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS_IN_USE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_CLAMP,
        ST_LOG,
        ST_EVAL,
        ST_POP,
        ST_ASC,
        ST_FINISH
    } state_t;

    // Levels in use, forced into 1..MAX_LEVELS.
    function automatic logic [BLK_W-1:0] eff_levels(input logic [LVL_W-1:0] lv);
        logic [BLK_W-1:0] r;
        if (lv == '0) begin
            r = BLK_W'(1);
        end else if (int'(lv) > MAX_LEVELS) begin
            r = BLK_W'(MAX_LEVELS);
        end else begin
            r = BLK_W'(lv);
        end
        return r;
    endfunction

    // Smallest k with 2^k >= v, for 1 <= v <= 32768.
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] w;
        logic [LOG_W:0]    k;
        w = v - SIZE_W'(1);
        k = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (w[i]) k = (LOG_W+1)'(i + 1);
        end
        return k[LOG_W-1:0];
    endfunction

    // Half edge of a node at this depth in 1/16 of the half map; finer levels drop out.
    function automatic logic [POS_W-1:0] node_offset(input logic [BLK_W-1:0] depth);
        logic [POS_W-1:0] off;
        if (depth >= BLK_W'(1) && depth <= BLK_W'(4)) begin
            off = POS_W'(5'b10000 >> depth);
        end else begin
            off = '0;
        end
        return off;
    endfunction

    function automatic logic [POS_W-1:0] child_dx(input logic [1:0] digit,
                                                  input logic [BLK_W-1:0] depth);
        logic [POS_W-1:0] off;
        off = node_offset(depth);
        return (digit < 2'd2) ? POS_W'(-off) : off;
    endfunction

    function automatic logic [POS_W-1:0] child_dy(input logic [1:0] digit,
                                                  input logic [BLK_W-1:0] depth);
        logic [POS_W-1:0] off;
        off = node_offset(depth);
        return (digit == 2'd0 || digit == 2'd3) ? off : POS_W'(-off);
    endfunction

endpackage

// ----- design/quadtree_tile_allocator_unit.sv -----
// Quadtree tile allocator: walks a block-level memory of the full quadtree.
// Depends on qta_pkg.
//
// Usage: one request on the s_ channel, one result on the m_ channel.
// s_tuser selects the request kind (allocate or clear), s_tdata carries the
// tile edge in texels. m_tuser says whether a tile was found, m_tdata carries
// its centre, level and the clamped size. The user must write the registers
// through the cfg_ port only while the block is idle; the block does not
// enforce this. Every register write starts a clearing pass. ST_IDLE takes
// the request, ST_CLAMP clamps the size, ST_LOG finds the level, ST_EVAL and
// ST_POP walk the tree depth-first (at most 340 visits plus climbs back),
// ST_ASC marks the tile and its ancestors below the root, and ST_FINISH posts
// the result. The walk is set by the single read port of the block-level
// memory, one node per cycle. A clear posts its result, then runs the clearing
// pass. Reset, a clear and every register write start a clearing pass that
// zeroes all 341 memory entries, one per cycle; s_tready stays low meanwhile.
// One request is in work at a time. The result waits in an output register
// while m_tready is low; the next request is still taken, and its result is
// held back until the output register is free.
module quadtree_tile_allocator_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] tile_size
    input  logic [qta_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] operation
    input  logic [qta_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] tile_pos_x, [9:5] tile_pos_y, [12:10] tile_level, [28:13] clamped_size
    output logic [qta_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] found
    output logic [qta_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [qta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qta_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import qta_pkg::*;

    state_t               state_reg, state_next;
    logic [LOG_W-1:0]     map_log2_reg, map_log2_next;
    logic [LOG_W-1:0]     max_log2_reg, max_log2_next;
    logic [LVL_W-1:0]     levels_reg, levels_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SIZE_W-1:0]    clamped_reg, clamped_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [NODE_W-1:0]    idx_reg, idx_next;
    logic [BLK_W-1:0]     depth_reg, depth_next;
    logic [NODE_W-1:0]    sweep_reg, sweep_next;
    logic [POS_W-1:0]     pos_x_reg, pos_x_next;
    logic [POS_W-1:0]     pos_y_reg, pos_y_next;
    logic                 found_reg, found_next;
    logic                 clr_reg, clr_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_found_reg, m_found_next;
    logic [POS_W-1:0]     m_x_reg, m_x_next;
    logic [POS_W-1:0]     m_y_reg, m_y_next;
    logic [LEVEL_W-1:0]   m_level_reg, m_level_next;
    logic [SIZE_W-1:0]    m_clamped_reg, m_clamped_next;

    // Block-level memory, one read and one write port, registered read data.
    logic [BLK_W-1:0]     blk_mem [NODE_COUNT];
    logic [BLK_W-1:0]     blk_rdata_reg;
    logic                 mem_we, mem_re;
    logic [NODE_W-1:0]    mem_waddr, mem_raddr;
    logic [BLK_W-1:0]     mem_wdata;

    logic [BLK_W-1:0]     eff;
    logic [NODE_W-1:0]    idx_m1, parent, child0;
    logic [NODE_W+1:0]    child0_w;
    logic [1:0]           digit;
    logic [LOG_W:0]       minl_w;
    logic [LOG_W-1:0]     minl, k_log;
    logic [SIZE_W-1:0]    lo, hi, clamped_c;
    logic [REQ_W-1:0]     req_c;
    logic                 accept;

    // Reads happen only during a walk and writes only while marking or clearing,
    // so the sequencer never reads and writes the same entry in one cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            blk_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            blk_rdata_reg <= blk_mem[mem_raddr];
        end
    end

    assign eff      = eff_levels(levels_reg);
    assign idx_m1   = idx_reg - NODE_W'(1);
    assign digit    = idx_m1[1:0];
    assign parent   = NODE_W'(idx_m1 >> 2);
    assign child0_w = {idx_reg, 2'b00} + (NODE_W+2)'(1);
    assign child0   = child0_w[NODE_W-1:0];

    assign minl_w    = (LOG_W+1)'(map_log2_reg) - ((LOG_W+1)'(eff) - (LOG_W+1)'(1));
    assign minl      = minl_w[LOG_W] ? '0 : minl_w[LOG_W-1:0];
    assign lo        = SIZE_W'(1) << minl;
    assign hi        = SIZE_W'(1) << max_log2_reg;
    assign clamped_c = (size_reg < lo) ? lo : ((size_reg > hi) ? hi : size_reg);
    assign k_log     = ceil_log2(clamped_reg);
    assign req_c     = map_log2_reg - k_log;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        map_log2_next  = map_log2_reg;
        max_log2_next  = max_log2_reg;
        levels_next    = levels_reg;
        size_next      = size_reg;
        clamped_next   = clamped_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        depth_next     = depth_reg;
        sweep_next     = sweep_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        found_next     = found_reg;
        clr_next       = clr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_found_next   = m_found_reg;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_level_next   = m_level_reg;
        m_clamped_next = m_clamped_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    found_next = 1'b0;
                    pos_x_next = '0;
                    pos_y_next = '0;
                    if (s_tuser[0] == OP_CLEAR) begin
                        clr_next     = 1'b1;
                        clamped_next = '0;
                        state_next   = ST_FINISH;
                    end else begin
                        clr_next   = 1'b0;
                        size_next  = s_tdata[SIZE_W-1:0];
                        state_next = ST_CLAMP;
                    end
                end
            end
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = '0;
                if (sweep_reg == NODE_W'(NODE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + NODE_W'(1);
                end
            end
            ST_CLAMP: begin
                clamped_next = clamped_c;
                state_next   = ST_LOG;
            end
            ST_LOG: begin
                req_next = req_c;
                if (k_log <= map_log2_reg && req_c >= REQ_W'(1)
                        && int'(req_c) < int'(eff)) begin
                    // Start at the first child of the root.
                    mem_re     = 1'b1;
                    mem_raddr  = NODE_W'(1);
                    idx_next   = NODE_W'(1);
                    depth_next = BLK_W'(1);
                    state_next = ST_EVAL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_EVAL: begin
                if (int'(blk_rdata_reg) > int'(req_reg)) begin
                    // Skip this subtree: advance to the next sibling, climb, or give up past the root's last child.
                    if (digit != 2'd3) begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_reg + NODE_W'(1);
                        idx_next   = idx_reg + NODE_W'(1);
                    end else if (depth_reg == BLK_W'(1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = parent;
                        depth_next = depth_reg - BLK_W'(1);
                        state_next = ST_POP;
                    end
                end else if (int'(depth_reg) == int'(req_reg)) begin
                    state_next = ST_ASC;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = child0;
                    idx_next   = child0;
                    depth_next = depth_reg + BLK_W'(1);
                end
            end
            ST_POP: begin
                if (digit != 2'd3) begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_reg + NODE_W'(1);
                    idx_next   = idx_reg + NODE_W'(1);
                    state_next = ST_EVAL;
                end else if (depth_reg == BLK_W'(1)) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = parent;
                    depth_next = depth_reg - BLK_W'(1);
                end
            end
            ST_ASC: begin
                // Mark the tile full, then raise each ancestor on the walk path.
                // Those ancestors passed the skip test, so raising means writing req.
                // The root's mark is never consulted and is left alone.
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = (int'(depth_reg) == int'(req_reg)) ? eff : BLK_W'(req_reg);
                pos_x_next = pos_x_reg + child_dx(digit, depth_reg);
                pos_y_next = pos_y_reg + child_dy(digit, depth_reg);
                if (depth_reg == BLK_W'(1)) begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = parent;
                    depth_next = depth_reg - BLK_W'(1);
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_found_next   = found_reg;
                    m_x_next       = pos_x_reg;
                    m_y_next       = pos_y_reg;
                    m_level_next   = found_reg ? req_reg[LEVEL_W-1:0] : '0;
                    m_clamped_next = clamped_reg;
                    if (clr_reg) begin
                        sweep_next = '0;
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write re-initializes the tree.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAP_SIZE_LOG2: begin
                    map_log2_next = cfg_wdata[LOG_W-1:0];
                    sweep_next    = '0;
                    state_next    = ST_SWEEP;
                end
                REG_MAX_TILE_LOG2: begin
                    max_log2_next = cfg_wdata[LOG_W-1:0];
                    sweep_next    = '0;
                    state_next    = ST_SWEEP;
                end
                REG_LEVELS_IN_USE: begin
                    levels_next = cfg_wdata[LVL_W-1:0];
                    sweep_next  = '0;
                    state_next  = ST_SWEEP;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            sweep_reg    <= '0;
            map_log2_reg <= LOG_W'(12);
            max_log2_reg <= LOG_W'(10);
            levels_reg   <= LVL_W'(5);
            m_tvalid_reg <= 1'b0;
            clr_reg      <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            map_log2_reg <= map_log2_next;
            max_log2_reg <= max_log2_next;
            levels_reg   <= levels_next;
            m_tvalid_reg <= m_tvalid_next;
            clr_reg      <= clr_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg      <= size_next;
        clamped_reg   <= clamped_next;
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        depth_reg     <= depth_next;
        pos_x_reg     <= pos_x_next;
        pos_y_reg     <= pos_y_next;
        m_found_reg   <= m_found_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_level_reg   <= m_level_next;
        m_clamped_reg <= m_clamped_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = M_TUSER_W'(m_found_reg);
    assign m_tdata  = M_TDATA_W'({m_clamped_reg, m_level_reg, m_y_reg, m_x_reg});

endmodule

// ----- design/qta_checker.sv -----
// Port-level checker of the quadtree tile allocator, bound to the top level.
// Depends on qta_pkg and quadtree_tile_allocator_unit_macros.svh.
`include "quadtree_tile_allocator_unit_macros.svh"

module qta_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [qta_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [qta_pkg::M_TUSER_W-1:0]    m_tuser
);
    import qta_pkg::*;

    // Reset empties the output register.
    `QTA_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // A stalled result holds.
    `QTA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // One request in work at a time.
    `QTA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A failed request or a clear carries no position and no level.
    `QTA_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[12:0] == 13'd0)

    // A found tile never sits at the root.
    `QTA_ASSERT_IMPL(a_found_level, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[12:10] != 3'd0)

endmodule

bind quadtree_tile_allocator_unit qta_checker u_qta_checker (.*);

// ----- tb/sv/quadtree_tile_allocator_unit_tb.sv -----
// Self-checking testbench for the quadtree tile allocator: a scoreboard class predicts
// each tile placement from its own copy of the block-level tree and checks every result.
// Depends on qta_pkg and quadtree_tile_allocator_unit.
module quadtree_tile_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int CFG_SETTLE      = 400;
    localparam int DRAIN_CYCLES    = 500;
    localparam int HOLD_CYCLES     = 1500;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 108;

    typedef struct packed {
        logic                          found;
        logic [qta_pkg::POS_W-1:0]     pos_x;
        logic [qta_pkg::POS_W-1:0]     pos_y;
        logic [qta_pkg::LEVEL_W-1:0]   level;
        logic [qta_pkg::SIZE_W-1:0]    clamped_size;
    } tile_result_t;

    class tile_scoreboard;
        bit [qta_pkg::BLK_W-1:0] block_lvl [qta_pkg::NODE_COUNT];
        bit [3:0]                map_log2;
        bit [3:0]                max_tile_log2;
        bit [2:0]                levels_cfg;
        tile_result_t            placement_q[$];
        int                      errors;
        int                      results_seen;

        function new();
            map_log2      = 4'd12;
            max_tile_log2 = 4'd10;
            levels_cfg    = 3'd5;
            errors        = 0;
            results_seen  = 0;
            clear_marks();
        endfunction

        function void clear_marks();
            foreach (block_lvl[i]) block_lvl[i] = '0;
        endfunction

        function void write_reg(logic [qta_pkg::CFG_IDX_W-1:0] idx,
                                logic [qta_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                qta_pkg::REG_MAP_SIZE_LOG2: map_log2 = val;
                qta_pkg::REG_MAX_TILE_LOG2: max_tile_log2 = val;
                qta_pkg::REG_LEVELS_IN_USE: levels_cfg = val[2:0];
                default: return;
            endcase
            // any write rebuilds the tree
            clear_marks();
        endfunction

        function int active_levels();
            int lv;
            lv = int'(levels_cfg);
            if (lv < 1) lv = 1;
            if (lv > qta_pkg::MAX_LEVELS) lv = qta_pkg::MAX_LEVELS;
            return lv;
        endfunction

        // First free node at the required level in depth-first child order 0..3.
        function tile_result_t allocate(logic [qta_pkg::SIZE_W-1:0] size);
            tile_result_t r;
            int eff, minl, lo, hi, sz, clamped, k, req, n, node, c, off, px, py;
            int path [qta_pkg::MAX_LEVELS];
            bit hit, fits;
            r = '0;
            eff = active_levels();
            minl = int'(map_log2) - (eff - 1);
            if (minl < 0) minl = 0;
            lo = 1 << minl;
            hi = 1 << max_tile_log2;
            sz = int'(size);
            clamped = (sz < lo) ? lo : ((sz > hi) ? hi : sz);
            r.clamped_size = clamped[15:0];
            k = 0;
            while (k < 31 && (1 << k) < clamped) k++;
            if (k > int'(map_log2)) return r;
            req = int'(map_log2) - k;
            if (req < 1 || req >= eff) return r;
            n = 1 << (2 * req);
            hit = 1'b0;
            for (int j = 0; j < n && !hit; j++) begin
                node = 0;
                px = 0;
                py = 0;
                fits = 1'b1;
                // a blocked ancestor hides its whole subtree
                for (int d = 1; d <= req; d++) begin
                    c = (j >> (2 * (req - d))) & 3;
                    node = 4 * node + 1 + c;
                    off = 16 >> d;
                    px += (c < 2) ? -off : off;
                    py += (c == 0 || c == 3) ? off : -off;
                    path[d - 1] = node;
                    if (int'(block_lvl[node]) > req) fits = 1'b0;
                end
                if (fits) begin
                    hit = 1'b1;
                    block_lvl[node] = qta_pkg::BLK_W'(eff);
                    if (int'(block_lvl[0]) < req) block_lvl[0] = qta_pkg::BLK_W'(req);
                    for (int d = 0; d < req - 1; d++) begin
                        if (int'(block_lvl[path[d]]) < req)
                            block_lvl[path[d]] = qta_pkg::BLK_W'(req);
                    end
                    r.found = 1'b1;
                    r.pos_x = px[4:0];
                    r.pos_y = py[4:0];
                    r.level = req[2:0];
                end
            end
            return r;
        endfunction

        function void note_request(logic op, logic [qta_pkg::SIZE_W-1:0] size);
            if (op == qta_pkg::OP_CLEAR) begin
                clear_marks();
                placement_q.push_back('0);
            end else begin
                placement_q.push_back(allocate(size));
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] result %0d: %s got %0d, expected %0d",
                     $time, results_seen, what, got, want);
            errors++;
        endtask

        task check_result(logic [qta_pkg::M_TUSER_W-1:0] tuser,
                          logic [qta_pkg::M_TDATA_W-1:0] tdata);
            tile_result_t want;
            results_seen++;
            if (placement_q.size() == 0) begin
                report_mismatch("result with no request waiting", 1, 0);
                return;
            end
            want = placement_q.pop_front();
            if (tuser[0] !== want.found)
                report_mismatch("found", int'(tuser[0]), int'(want.found));
            if (tdata[4:0] !== want.pos_x)
                report_mismatch("tile_pos_x", int'(tdata[4:0]), int'(want.pos_x));
            if (tdata[9:5] !== want.pos_y)
                report_mismatch("tile_pos_y", int'(tdata[9:5]), int'(want.pos_y));
            if (tdata[12:10] !== want.level)
                report_mismatch("tile_level", int'(tdata[12:10]), int'(want.level));
            if (tdata[28:13] !== want.clamped_size)
                report_mismatch("clamped_size", int'(tdata[28:13]), int'(want.clamped_size));
        endtask
    endclass

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [qta_pkg::S_TDATA_W-1:0]      s_tdata   = '0;
    logic [qta_pkg::S_TUSER_W-1:0]      s_tuser   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [qta_pkg::M_TDATA_W-1:0]      m_tdata;
    logic [qta_pkg::M_TUSER_W-1:0]      m_tuser;
    logic                               cfg_wr_en = 1'b0;
    logic [qta_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [qta_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    tile_scoreboard sb;
    bit             idle_en     = 1'b1;
    int             hold_asked  = 0;
    int             hold_served = 0;
    int             hold_left   = 0;
    int             cycle_count = 0;

    // map_size_log2, max_tile_log2, levels_in_use per phase
    logic [3:0] phase_map [PHASES] = '{4'd15, 4'd4, 4'd10, 4'd14, 4'd8,
                                       4'd6, 4'd9, 4'd2, 4'd12, 4'd11};
    logic [3:0] phase_max [PHASES] = '{4'd15, 4'd4, 4'd15, 4'd4, 4'd6,
                                       4'd12, 4'd9, 4'd3, 4'd10, 4'd11};
    logic [3:0] phase_lvl [PHASES] = '{4'd5, 4'd5, 4'd3, 4'd2, 4'd1,
                                       4'd0, 4'd7, 4'd5, 4'd5, 4'd4};

    quadtree_tile_allocator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // Result side: random stalls, plus one long hold-off on demand.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = !(idle_en && $urandom_range(99) < 9);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(logic op, logic [qta_pkg::SIZE_W-1:0] size);
        if (idle_en) begin
            while ($urandom_range(99) < 9) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = size;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, size);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [qta_pkg::CFG_IDX_W-1:0] idx, logic [3:0] val);
        s_tvalid = 1'b0;
        while (sb.placement_q.size() != 0) @(negedge aclk);
        // let a clearing pass run out before touching the registers
        repeat (CFG_SETTLE) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic void pick_request(output logic op,
                                         output logic [qta_pkg::SIZE_W-1:0] size);
        int roll, eff, lvl, k;
        roll = $urandom_range(99);
        eff  = sb.active_levels();
        op   = qta_pkg::OP_ALLOC;
        size = 16'($urandom);
        if (roll < 3) begin
            op = qta_pkg::OP_CLEAR;
        end else if (roll < 13) begin
            // keep the raw random size
        end else if (roll < 20) begin
            case ($urandom_range(3))
                0: size = '0;
                1: size = '1;
                2: size = 16'(1 << $urandom_range(15));
                default: size = 16'((1 << $urandom_range(15)) + 1);
            endcase
        end else begin
            // aim at a level the tree can hold so it fills up between clears
            lvl = (eff > 1) ? int'($urandom_range(eff - 1, 1)) : int'($urandom_range(4, 1));
            k = int'(sb.map_log2) - lvl;
            if (k < 1) size = 16'($urandom_range(1));
            else size = 16'($urandom_range(1 << k, (1 << (k - 1)) + 1));
        end
    endfunction

    initial begin
        logic                          op;
        logic [qta_pkg::SIZE_W-1:0]    size;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values: sizes clamp to 256..1024, levels 2..4 reachable
        send_request(qta_pkg::OP_ALLOC, 16'h0000);
        send_request(qta_pkg::OP_ALLOC, 16'hFFFF);
        send_request(qta_pkg::OP_ALLOC, 16'd300);
        send_request(qta_pkg::OP_CLEAR, 16'hFFFF);
        // fill every level-2 tile, then one more must fail
        for (int i = 0; i < 17; i++) send_request(qta_pkg::OP_ALLOC, 16'd1024);
        send_request(qta_pkg::OP_ALLOC, 16'h0001);
        send_request(qta_pkg::OP_CLEAR, 16'h0000);
        send_request(qta_pkg::OP_ALLOC, 16'h5555);
        send_request(qta_pkg::OP_ALLOC, 16'hAAAA);

        for (int p = 0; p < PHASES; p++) begin
            write_reg(qta_pkg::REG_MAP_SIZE_LOG2, phase_map[p]);
            write_reg(qta_pkg::REG_MAX_TILE_LOG2, phase_max[p]);
            write_reg(qta_pkg::REG_LEVELS_IN_USE, phase_lvl[p]);
            idle_en = (p != 8);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // stall the result side long enough to back up the request side
                if (p == 9 && i == 20) hold_asked++;
                pick_request(op, size);
                send_request(op, size);
            end
        end
        s_tvalid = 1'b0;

        while (sb.placement_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
